### design/gsbpt_pkg.sv
// Shared types and constants for the GPS-synced blink phase timer.
// Used by gsbpt_clock, gsbpt_phase and gps_synced_blink_phase_timer.
// No dependencies.
`default_nettype none

package gsbpt_pkg;

    // Default clock ticks per second (one tick = one input item)
    localparam int unsigned TICKS_PER_SECOND_DEFAULT = 1000;

    // Field widths
    localparam int unsigned MS_W     = 10;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned MIN_W    = 6;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned OFFSET_W = 27;
    localparam int unsigned STEP_W   = $clog2(OFFSET_W);

    // Time-of-day limits
    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned MIN_PER_HOUR = 60;
    localparam int unsigned HOUR_PER_DAY = 24;
    localparam int unsigned LAST_SECOND  = 59;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] CYCLE_MS_RESET = 16'd1000;
    localparam logic [CFG_W-1:0] ON_MS_RESET    = 16'd500;

    // Configuration register indexes
    typedef enum logic
    {
        REG_CYCLE_MS = 1'b0,
        REG_ON_MS    = 1'b1
    } cfg_reg_t;

    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [CFG_W-1:0]    cfg_word_t;

    // Local clock as seen by the datapath and the output stage
    typedef struct packed
    {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic [MS_W-1:0]   millisecond;
    } clock_time_t;

    // Operations of the shared multiply-accumulate / modulo unit
    typedef enum logic [2:0]
    {
        OP_HOLD,
        OP_LOAD_HOUR,
        OP_ADD_MINUTE,
        OP_ADD_SECOND,
        OP_ADD_TICK,
        OP_MOD_STEP
    } phase_op_t;

endpackage

`default_nettype wire

### design/gsbpt_clock.sv
// Local time-of-day counters with GPS time latch and PPS edge resync.
// Depends on gsbpt_pkg.
`default_nettype none

module gsbpt_clock #(
    parameter int unsigned TICKS_PER_SECOND = gsbpt_pkg::TICKS_PER_SECOND_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic                          pps_level,
    input  wire logic                          gps_load,
    input  wire logic [gsbpt_pkg::HOUR_W-1:0]  gps_hour,
    input  wire logic [gsbpt_pkg::MIN_W-1:0]   gps_minute,
    input  wire logic [gsbpt_pkg::SEC_W-1:0]   gps_second,
    output gsbpt_pkg::clock_time_t             now
);

    localparam logic [gsbpt_pkg::MS_W-1:0] LastTick =
        gsbpt_pkg::MS_W'(TICKS_PER_SECOND - 1);

    logic [gsbpt_pkg::MS_W-1:0]   ms_reg,   ms_next;
    logic [gsbpt_pkg::SEC_W-1:0]  sec_reg,  sec_next;
    logic [gsbpt_pkg::MIN_W-1:0]  min_reg,  min_next;
    logic [gsbpt_pkg::HOUR_W-1:0] hour_reg, hour_next;
    logic [gsbpt_pkg::HOUR_W-1:0] lat_hour_reg, lat_hour_next;
    logic [gsbpt_pkg::MIN_W-1:0]  lat_min_reg,  lat_min_next;
    logic [gsbpt_pkg::SEC_W-1:0]  lat_sec_reg,  lat_sec_next;
    logic                         pps_prev_reg;

    logic [gsbpt_pkg::MS_W-1:0]   ms_base;
    logic [gsbpt_pkg::SEC_W-1:0]  sec_base;
    logic [gsbpt_pkg::MIN_W-1:0]  min_base;
    logic [gsbpt_pkg::HOUR_W-1:0] hour_base;
    logic [gsbpt_pkg::MS_W:0]     ms_inc;
    logic [gsbpt_pkg::SEC_W:0]    sec_inc;
    logic [gsbpt_pkg::MIN_W:0]    min_inc;
    logic [gsbpt_pkg::HOUR_W:0]   hour_inc;
    logic                         resync;

    // Latch, edge check, then advance by one tick
    always_comb
    begin
        lat_hour_next = gps_load ? gps_hour   : lat_hour_reg;
        lat_min_next  = gps_load ? gps_minute : lat_min_reg;
        lat_sec_next  = gps_load ? gps_second : lat_sec_reg;

        resync = pps_level && !pps_prev_reg
                 && (lat_sec_next == gsbpt_pkg::SEC_W'(gsbpt_pkg::LAST_SECOND));

        ms_base   = ms_reg;
        sec_base  = sec_reg;
        min_base  = min_reg;
        hour_base = hour_reg;
        if (resync)
        begin
            ms_base      = LastTick;
            sec_base     = lat_sec_next;
            min_base     = lat_min_next;
            hour_base    = lat_hour_next;
            lat_sec_next = '0;
        end

        ms_inc   = {1'b0, ms_base} + 1'b1;
        sec_inc  = {1'b0, sec_base} + 1'b1;
        min_inc  = {1'b0, min_base} + 1'b1;
        hour_inc = {1'b0, hour_base} + 1'b1;

        ms_next   = ms_inc[gsbpt_pkg::MS_W-1:0];
        sec_next  = sec_base;
        min_next  = min_base;
        hour_next = hour_base;

        // Carry chain; each test is "reached or passed the limit"
        if (ms_inc >= (gsbpt_pkg::MS_W+1)'(TICKS_PER_SECOND))
        begin
            ms_next  = '0;
            sec_next = sec_inc[gsbpt_pkg::SEC_W-1:0];
            if (sec_inc >= (gsbpt_pkg::SEC_W+1)'(gsbpt_pkg::SEC_PER_MIN))
            begin
                sec_next = '0;
                min_next = min_inc[gsbpt_pkg::MIN_W-1:0];
                if (min_inc >= (gsbpt_pkg::MIN_W+1)'(gsbpt_pkg::MIN_PER_HOUR))
                begin
                    min_next  = '0;
                    hour_next = hour_inc[gsbpt_pkg::HOUR_W-1:0];
                    if (hour_inc >= (gsbpt_pkg::HOUR_W+1)'(gsbpt_pkg::HOUR_PER_DAY))
                    begin
                        hour_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg       <= '0;
            sec_reg      <= '0;
            min_reg      <= '0;
            hour_reg     <= '0;
            lat_hour_reg <= '0;
            lat_min_reg  <= '0;
            lat_sec_reg  <= '0;
            pps_prev_reg <= 1'b0;
        end
        else if (step)
        begin
            ms_reg       <= ms_next;
            sec_reg      <= sec_next;
            min_reg      <= min_next;
            hour_reg     <= hour_next;
            lat_hour_reg <= lat_hour_next;
            lat_min_reg  <= lat_min_next;
            lat_sec_reg  <= lat_sec_next;
            pps_prev_reg <= pps_level;
        end
    end

    assign now.hour        = hour_reg;
    assign now.minute      = min_reg;
    assign now.second      = sec_reg;
    assign now.millisecond = ms_reg;

endmodule

`default_nettype wire

### design/gsbpt_phase.sv
// Shared multiply-accumulate / restoring modulo unit for the blink phase.
// Builds the tick-of-day value, then reduces it modulo the period one bit a step.
// Depends on gsbpt_pkg.
`default_nettype none

module gsbpt_phase #(
    parameter int unsigned TICKS_PER_SECOND = gsbpt_pkg::TICKS_PER_SECOND_DEFAULT
) (
    input  wire logic                       clk,
    input  wire gsbpt_pkg::phase_op_t       op,
    input  wire gsbpt_pkg::clock_time_t     now,
    input  wire gsbpt_pkg::cfg_word_t       divisor,
    output gsbpt_pkg::cfg_word_t            remainder
);

    localparam int unsigned MinuteTicks = gsbpt_pkg::SEC_PER_MIN * TICKS_PER_SECOND;
    localparam int unsigned HourTicks   = gsbpt_pkg::MIN_PER_HOUR * MinuteTicks;
    localparam int unsigned KW          = $clog2(HourTicks + 1);
    localparam int unsigned PW          = gsbpt_pkg::MS_W + KW;

    gsbpt_pkg::offset_t          acc_reg, acc_next;
    gsbpt_pkg::cfg_word_t        rem_reg, rem_next;
    logic [gsbpt_pkg::MS_W-1:0]  mul_a;
    logic [KW-1:0]               mul_k;
    logic [PW-1:0]               product;
    gsbpt_pkg::offset_t          acc_base;
    logic [gsbpt_pkg::CFG_W:0]   shifted;
    logic                        fits;

    // Operand selection for the multiplier
    always_comb
    begin
        unique case (op)
            gsbpt_pkg::OP_LOAD_HOUR:
            begin
                mul_a = gsbpt_pkg::MS_W'(now.hour);
                mul_k = KW'(HourTicks);
            end
            gsbpt_pkg::OP_ADD_MINUTE:
            begin
                mul_a = gsbpt_pkg::MS_W'(now.minute);
                mul_k = KW'(MinuteTicks);
            end
            gsbpt_pkg::OP_ADD_SECOND:
            begin
                mul_a = gsbpt_pkg::MS_W'(now.second);
                mul_k = KW'(TICKS_PER_SECOND);
            end
            gsbpt_pkg::OP_ADD_TICK:
            begin
                mul_a = now.millisecond;
                mul_k = KW'(1);
            end
            default:
            begin
                mul_a = '0;
                mul_k = '0;
            end
        endcase
    end

    assign product  = PW'(mul_a) * PW'(mul_k);
    assign acc_base = (op == gsbpt_pkg::OP_LOAD_HOUR) ? '0 : acc_reg;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, acc_reg[gsbpt_pkg::OFFSET_W-1]};
    assign fits    = shifted >= {1'b0, divisor};

    always_comb
    begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        unique case (op)
            gsbpt_pkg::OP_LOAD_HOUR,
            gsbpt_pkg::OP_ADD_MINUTE,
            gsbpt_pkg::OP_ADD_SECOND,
            gsbpt_pkg::OP_ADD_TICK:
            begin
                acc_next = acc_base + gsbpt_pkg::offset_t'(product);
                rem_next = '0;
            end
            gsbpt_pkg::OP_MOD_STEP:
            begin
                acc_next = {acc_reg[gsbpt_pkg::OFFSET_W-2:0], 1'b0};
                rem_next = fits ? gsbpt_pkg::CFG_W'(shifted - {1'b0, divisor})
                                : gsbpt_pkg::CFG_W'(shifted);
            end
            default:
            begin
                acc_next = acc_reg;
                rem_next = rem_reg;
            end
        endcase
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign remainder = rem_reg;

endmodule

`default_nettype wire

### design/gps_synced_blink_phase_timer.sv
// Blink-phase timer locked to GPS time of day: top level with item sequencer.
// Depends on gsbpt_pkg, gsbpt_clock and gsbpt_phase.
//
// Usage:
//   s_axis carries one item per clock tick (pps level, gps time, load flag in tuser).
//   m_axis returns one item per input item: lamp state and the local time after
//   the tick has been applied. cfg writes the period (index 0) and the on time
//   (index 1) and is always ready. It is to be written only while the block is
//   idle; the user must keep to this, as the block itself does not enforce it.
// Sequence:
//   An accepted item updates the clock at once; the shared unit then forms
//   the tick of day (one multiply-add each for hour, minute, second, tick),
//   reduces it bit-serially modulo the period, and the result is registered.
//   Items do not overlap: s_axis_tready is high only while the sequencer is idle.
// Reset:
//   rst_n clears the clock, the latched GPS time, the PPS history and the
//   sequencer; the period returns to 1000 ticks and the on time to 500.
// Stall:
//   A result held by m_axis_tready low stays in the output register; the next
//   item is accepted and processed meanwhile, and waits to complete until the
//   held result is taken.
`default_nettype none

module gps_synced_blink_phase_timer #(
    parameter int unsigned TICKS_PER_SECOND = gsbpt_pkg::TICKS_PER_SECOND_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] pps_level, [5:1] gps_hour, [11:6] gps_minute, [17:12] gps_second
    input  wire logic [23:0] s_axis_tdata,
    // [0] gps_load
    input  wire logic        s_axis_tuser,
    // Result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] lamp_on, [10:1] millisecond, [16:11] second, [22:17] minute, [27:23] hour
    output logic [31:0]      m_axis_tdata,
    // Configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_HOUR,
        S_MINUTE,
        S_SECOND,
        S_TICK,
        S_MOD,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [gsbpt_pkg::STEP_W-1:0]    step_cnt_reg, step_cnt_next;
    logic                            m_valid_reg, m_valid_next;
    logic [31:0]                     m_data_reg, m_data_next;
    gsbpt_pkg::cfg_word_t            cycle_ms_reg;
    gsbpt_pkg::cfg_word_t            on_ms_reg;

    gsbpt_pkg::phase_op_t            op;
    gsbpt_pkg::clock_time_t          now;
    gsbpt_pkg::cfg_word_t            remainder;
    logic                            accept;
    logic                            lamp;
    logic                            out_free;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_ms_reg <= gsbpt_pkg::CYCLE_MS_RESET;
            on_ms_reg    <= gsbpt_pkg::ON_MS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (gsbpt_pkg::cfg_reg_t'(cfg_index))
                gsbpt_pkg::REG_CYCLE_MS: cycle_ms_reg <= cfg_data;
                gsbpt_pkg::REG_ON_MS:    on_ms_reg    <= cfg_data;
            endcase
        end
    end

    gsbpt_clock #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_clock (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .pps_level  (s_axis_tdata[0]),
        .gps_load   (s_axis_tuser),
        .gps_hour   (s_axis_tdata[5:1]),
        .gps_minute (s_axis_tdata[11:6]),
        .gps_second (s_axis_tdata[17:12]),
        .now        (now)
    );

    gsbpt_phase #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_phase (
        .clk       (clk),
        .op        (op),
        .now       (now),
        .divisor   (cycle_ms_reg),
        .remainder (remainder)
    );

    // The counters only change h/m/s on a tick wrap, so rebuilding the
    // day offset on every item gives the same value as at tick zero.
    assign lamp = (cycle_ms_reg != '0) && (remainder < on_ms_reg);

    // Sequencer and output register
    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        op            = gsbpt_pkg::OP_HOLD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HOUR;
                end
            end
            S_HOUR:
            begin
                op         = gsbpt_pkg::OP_LOAD_HOUR;
                state_next = S_MINUTE;
            end
            S_MINUTE:
            begin
                op         = gsbpt_pkg::OP_ADD_MINUTE;
                state_next = S_SECOND;
            end
            S_SECOND:
            begin
                op         = gsbpt_pkg::OP_ADD_SECOND;
                state_next = S_TICK;
            end
            S_TICK:
            begin
                op            = gsbpt_pkg::OP_ADD_TICK;
                step_cnt_next = gsbpt_pkg::STEP_W'(gsbpt_pkg::OFFSET_W - 1);
                state_next    = S_MOD;
            end
            S_MOD:
            begin
                op            = gsbpt_pkg::OP_MOD_STEP;
                step_cnt_next = step_cnt_reg - 1'b1;
                if (step_cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0, now.hour, now.minute, now.second,
                                    now.millisecond, lamp};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Block stays busy for the whole computation after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("input accepted again while an item is in progress");

    // Tick counter never reaches a full second
    assert property (@(posedge clk) disable iff (!rst_n)
        now.millisecond < gsbpt_pkg::MS_W'(TICKS_PER_SECOND))
        else $error("tick counter out of range");

    // Modulo result is reduced below a non-zero period
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && cycle_ms_reg != '0) |-> remainder < cycle_ms_reg)
        else $error("phase not reduced below period");

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking bench for gps_synced_blink_phase_timer: ticks with PPS and GPS time go in,
// each result is checked against a local clock-and-lamp predictor. Depends on gsbpt_pkg
// and the RTL under design/.
`default_nettype none

module testbench;

    localparam int unsigned TICKS       = gsbpt_pkg::TICKS_PER_SECOND_DEFAULT;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          SETTLE      = 40;

    // One input tick and one local-time result
    typedef struct
    {
        bit                         pps;
        bit                         load;
        bit [gsbpt_pkg::HOUR_W-1:0] hour;
        bit [gsbpt_pkg::MIN_W-1:0]  minute;
        bit [gsbpt_pkg::SEC_W-1:0]  second;
    } tick_t;

    typedef struct
    {
        bit                         lamp;
        bit [gsbpt_pkg::MS_W-1:0]   millisecond;
        bit [gsbpt_pkg::SEC_W-1:0]  second;
        bit [gsbpt_pkg::MIN_W-1:0]  minute;
        bit [gsbpt_pkg::HOUR_W-1:0] hour;
    } local_time_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [23:0]            s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [31:0]            m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    gsbpt_pkg::cfg_reg_t    cfg_index = gsbpt_pkg::REG_CYCLE_MS;
    gsbpt_pkg::cfg_word_t   cfg_data = '0;

    // Stimulus and expectations
    tick_t       tick_queue[$];
    local_time_t expected_times[$];
    tick_t       cur_tick;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // Pacing of both sides
    int gap_cnt = 0;
    int send_calm = 0;
    int stall_cnt = 0;
    int recv_calm = 0;

    // Predicted clock state and registers
    int unsigned tk_ms = 0;
    int unsigned tk_sec = 0;
    int unsigned tk_min = 0;
    int unsigned tk_hour = 0;
    gsbpt_pkg::offset_t         day_ofs = '0;
    bit [gsbpt_pkg::HOUR_W-1:0] lat_hour = '0;
    bit [gsbpt_pkg::MIN_W-1:0]  lat_min = '0;
    bit [gsbpt_pkg::SEC_W-1:0]  lat_sec = '0;
    bit                         pps_seen = 1'b0;
    gsbpt_pkg::cfg_word_t       period_ticks = gsbpt_pkg::CYCLE_MS_RESET;
    gsbpt_pkg::cfg_word_t       on_ticks = gsbpt_pkg::ON_MS_RESET;

    gps_synced_blink_phase_timer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one tick to the predicted clock and return the local time after it
    function automatic local_time_t advance_tick(input tick_t t);
        local_time_t r;
        if (t.load)
        begin
            lat_hour = t.hour;
            lat_min  = t.minute;
            lat_sec  = t.second;
        end
        // rising PPS edge with a latched second of 59 sets the clock
        if (t.pps && !pps_seen && lat_sec == gsbpt_pkg::LAST_SECOND)
        begin
            tk_ms   = TICKS - 1;
            tk_sec  = lat_sec;
            tk_min  = lat_min;
            tk_hour = lat_hour;
            lat_sec = '0;
        end
        pps_seen = t.pps;
        // carries use >= so out-of-range values wrap on the next carry
        tk_ms++;
        if (tk_ms >= TICKS)
        begin
            tk_ms = 0;
            tk_sec++;
            if (tk_sec >= gsbpt_pkg::SEC_PER_MIN)
            begin
                tk_sec = 0;
                tk_min++;
                if (tk_min >= gsbpt_pkg::MIN_PER_HOUR)
                begin
                    tk_min = 0;
                    tk_hour++;
                    if (tk_hour >= gsbpt_pkg::HOUR_PER_DAY)
                        tk_hour = 0;
                end
            end
        end
        if (tk_ms == 0)
            day_ofs = gsbpt_pkg::offset_t'((tk_hour * 3600 + tk_min * 60 + tk_sec) * TICKS);
        // a zero period keeps the lamp off
        if (period_ticks == 0)
            r.lamp = 1'b0;
        else
            r.lamp = ((day_ofs + tk_ms) % period_ticks) < on_ticks;
        r.millisecond = gsbpt_pkg::MS_W'(tk_ms);
        r.second      = gsbpt_pkg::SEC_W'(tk_sec);
        r.minute      = gsbpt_pkg::MIN_W'(tk_min);
        r.hour        = gsbpt_pkg::HOUR_W'(tk_hour);
        return r;
    endfunction

    // Wait length for the next item, with occasional stretches of none
    function automatic int draw_wait(inout int calm);
        int n;
        n = 0;
        if (calm != 0)
            calm--;
        else
        begin
            n = $urandom_range(0, 3);
            if ($urandom_range(0, 39) == 0)
                calm = $urandom_range(20, 60);
        end
        return n;
    endfunction

    // Driver: presents queued ticks, waits count only while the block is ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            logic sent;
            sent = s_axis_tvalid && s_axis_tready;
            if (sent)
            begin
                expected_times.push_back(advance_tick(cur_tick));
                gap_cnt = draw_wait(send_calm);
            end
            if (sent || !s_axis_tvalid)
            begin
                if (gap_cnt != 0)
                begin
                    if (s_axis_tready && !sent)
                        gap_cnt--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    cur_tick = tick_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, cur_tick.second, cur_tick.minute,
                                      cur_tick.hour, cur_tick.pps};
                    s_axis_tuser  <= cur_tick.load;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: stalls per result, checks each item against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            local_time_t want;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_times.size() == 0)
                begin
                    $error("result item with no expectation: %h", m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_times.pop_front();
                    if (m_axis_tdata[0] !== want.lamp)
                    begin
                        $error("lamp_on: expected %0d, got %0d", want.lamp, m_axis_tdata[0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[10:1] !== want.millisecond)
                    begin
                        $error("millisecond: expected %0d, got %0d",
                               want.millisecond, m_axis_tdata[10:1]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[16:11] !== want.second)
                    begin
                        $error("second: expected %0d, got %0d", want.second, m_axis_tdata[16:11]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[22:17] !== want.minute)
                    begin
                        $error("minute: expected %0d, got %0d", want.minute, m_axis_tdata[22:17]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[27:23] !== want.hour)
                    begin
                        $error("hour: expected %0d, got %0d", want.hour, m_axis_tdata[27:23]);
                        mismatch_count++;
                    end
                end
                stall_cnt = draw_wait(recv_calm);
                m_axis_tready <= (stall_cnt == 0);
            end
            else if (m_axis_tvalid && !m_axis_tready)
            begin
                if (stall_cnt <= 1)
                begin
                    stall_cnt = 0;
                    m_axis_tready <= 1'b1;
                end
                else
                    stall_cnt--;
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_tick(input bit pps, input bit load, input int h, input int m,
                              input int s);
        tick_t t;
        t.pps    = pps;
        t.load   = load;
        t.hour   = gsbpt_pkg::HOUR_W'(h);
        t.minute = gsbpt_pkg::MIN_W'(m);
        t.second = gsbpt_pkg::SEC_W'(s);
        tick_queue.push_back(t);
    endtask

    // Plain tick: no load, ignored time fields random
    task automatic queue_idle(input bit pps);
        queue_tick(pps, 1'b0, $urandom_range(0, 31), $urandom_range(0, 63),
                   $urandom_range(0, 63));
    endtask

    // Mostly well-formed GPS seconds (time then PPS edge), some noise and long runs
    task automatic queue_random(input int count);
        int done;
        int kind;
        int k;
        int h;
        int m;
        int s;
        done = 0;
        while (done < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                k = $urandom_range(0, 5);
                repeat (k) queue_idle(1'b0);
                done += k;
                if ($urandom_range(0, 7) == 0)
                begin
                    h = $urandom_range(0, 31);
                    m = $urandom_range(0, 63);
                end
                else
                begin
                    h = $urandom_range(0, 23);
                    m = $urandom_range(0, 59);
                end
                s = ($urandom_range(0, 6) != 0) ? gsbpt_pkg::LAST_SECOND
                                                : $urandom_range(0, 63);
                // time sometimes arrives with the edge itself
                if ($urandom_range(0, 3) == 0)
                    queue_tick(1'b1, 1'b1, h, m, s);
                else
                    queue_tick(1'b0, 1'b1, h, m, s);
                done++;
                k = $urandom_range(1, 5);
                repeat (k - 1) queue_idle(1'b1);
                done += k - 1;
            end
            else if (kind == 7)
            begin
                k = $urandom_range(30, 120);
                repeat (k) queue_idle($urandom_range(0, 3) == 0);
                done += k;
            end
            else
            begin
                k = $urandom_range(1, 6);
                repeat (k)
                    queue_tick($urandom_range(0, 1), $urandom_range(0, 3) == 0,
                               $urandom_range(0, 31), $urandom_range(0, 63),
                               $urandom_range(0, 63));
                done += k;
            end
        end
    endtask

    // Long run without any clock setting, so the counter carries on its own
    task automatic queue_free_run(input int count);
        int s;
        queue_tick(1'b0, 1'b1, 0, 0, 0);
        repeat (count)
        begin
            s = $urandom_range(0, 63);
            if (s == gsbpt_pkg::LAST_SECOND)
                s = 0;
            queue_tick($urandom_range(0, 5) == 0, $urandom_range(0, 7) == 0,
                       $urandom_range(0, 31), $urandom_range(0, 63), s);
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (tick_queue.size() != 0 || s_axis_tvalid || expected_times.size() != 0);
    endtask

    task automatic write_reg(input gsbpt_pkg::cfg_reg_t idx, input gsbpt_pkg::cfg_word_t val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == gsbpt_pkg::REG_CYCLE_MS)
            period_ticks = val;
        else
            on_ticks = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_blink(input gsbpt_pkg::cfg_word_t period,
                             input gsbpt_pkg::cfg_word_t on_time);
        drain();
        write_reg(gsbpt_pkg::REG_CYCLE_MS, period);
        write_reg(gsbpt_pkg::REG_ON_MS, on_time);
        @(negedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed ticks at reset settings
        queue_tick(1'b0, 1'b0, 0, 0, 0);
        queue_tick(1'b0, 1'b1, 23, 59, 59);
        queue_tick(1'b1, 1'b0, 0, 0, 0);       // set to end of day, wraps to midnight
        queue_tick(1'b1, 1'b1, 12, 34, 59);    // level held high: no edge
        queue_tick(1'b0, 1'b0, 0, 0, 0);
        queue_tick(1'b1, 1'b0, 0, 0, 0);       // edge sets 12:34:59
        queue_tick(1'b0, 1'b1, 31, 63, 59);    // out-of-range hour and minute
        queue_tick(1'b1, 1'b0, 0, 0, 0);
        queue_tick(1'b0, 1'b1, 31, 58, 59);
        queue_tick(1'b1, 1'b0, 0, 0, 0);       // out-of-range hour shown and in offset
        queue_tick(1'b0, 1'b0, 0, 0, 0);
        queue_tick(1'b1, 1'b0, 0, 0, 0);       // edge after latched second cleared
        queue_tick(1'b0, 1'b0, 0, 0, 0);
        queue_tick(1'b1, 1'b1, 0, 0, 63);      // load and edge together, second not 59
        queue_tick(1'b0, 1'b0, 0, 0, 0);
        queue_tick(1'b1, 1'b1, 10, 20, 59);    // load and edge together, sets clock
        queue_tick(1'b1, 1'b1, 31, 63, 63);
        queue_tick(1'b0, 1'b1, 0, 0, 0);
        queue_tick(1'b0, 1'b1, 23, 0, 59);
        queue_tick(1'b1, 1'b0, 0, 0, 0);
        queue_tick(1'b0, 1'b0, 31, 63, 63);
        queue_random(30);
        drain();

        // Narrowest period, lamp never on
        set_blink(16'd1, 16'd0);
        queue_random(60);

        // Wide period, lamp always on
        set_blink(16'd60000, 16'd60000);
        queue_random(60);

        // Zero period
        set_blink(16'd0, 16'd500);
        queue_random(40);

        // Short period, counters run free past a second boundary
        set_blink(16'd7, 16'd3);
        queue_free_run(1010);

        // Random settings
        set_blink(gsbpt_pkg::cfg_word_t'($urandom_range(1, 60000)),
                  gsbpt_pkg::cfg_word_t'($urandom_range(0, 60000)));
        queue_random(40);
        set_blink(gsbpt_pkg::cfg_word_t'($urandom_range(1, 3000)),
                  gsbpt_pkg::cfg_word_t'($urandom_range(0, 3000)));
        queue_random(40);

        drain();
        repeat (SETTLE) @(posedge clk);
        while (expected_times.size() != 0)
        begin
            $error("expected result never came");
            void'(expected_times.pop_front());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
design/gsbpt_pkg.sv
design/gsbpt_clock.sv
design/gsbpt_phase.sv
design/gps_synced_blink_phase_timer.sv
dv/testbench.sv
